[sv/tlfc_pkg.sv]
// package for the two level fifo cache
// shared constants, payload structs and ram sizing; no dependencies

package tlfc_pkg;

	localparam int NEAR_DEPTH = 8;
	localparam int FAR_DEPTH  = 32;
	localparam int NEAR_AW    = 3;
	localparam int FAR_AW     = 5;
	localparam int NEAR_CW    = 4;
	localparam int FAR_CW     = 6;

	localparam logic [1:0] ST_L1_HIT = 2'd0;
	localparam logic [1:0] ST_L2_HIT = 2'd1;
	localparam logic [1:0] ST_MISS   = 2'd2;
	localparam logic [1:0] ST_WRITE  = 2'd3;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic REG_L1_CAP = 1'b0;
	localparam logic REG_L2_CAP = 1'b1;

	typedef struct packed {
		logic              op;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [31:0]        first_hits;
		logic [31:0]        first_misses;
		logic [31:0]        second_hits;
		logic [31:0]        second_misses;
	} out_item_t;

endpackage

[sv/tlfc_ram.sv]
// generic single port ram with registered read
// no dependencies

module tlfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[sv/two_level_fifo_cache.sv]
// top level of the two level fifo cache: sequencer, key compare and rams
// depends on tlfc_pkg and tlfc_ram
//
// usage: pulse start with an item on in_item while busy is low. busy rises the
// next cycle and stays high until the result strobe. done is high for one
// cycle with out_item; the receiver cannot stall it.
// each level is searched one entry at a time through a shared key comparator on
// a registered ram read: each probed entry passes through S_RD and then S_CMP.
// an l2 hit rescans l1 before the fill. busy falls with done, so the next item
// can be taken at the edge that ends the done cycle.
// cfg_we with cfg_index and cfg_data writes a capacity; the user must do so
// only while idle, as the block itself does not enforce it.
// reset clears both fill counts, heads and the saturating hit/miss counters and
// sets capacities to 8 and 32; ram contents are never read before written.
// a write updates an existing key in place or appends, evicting the oldest
// entry when the level is at capacity.

module two_level_fifo_cache (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tlfc_pkg::in_item_t in_item,
	output logic               done,
	output tlfc_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CMP, S_PUT_WR, S_EMIT
	} state_t;

	state_t state_q;
	logic   level_q;   // 0 near, 1 far
	logic   phase_q;   // 0 search for read, 1 put
	logic   wr_both_q;
	logic   op_q;
	logic [31:0] key_q, val_q, rv_q;
	logic [1:0]  status_q;
	logic [5:0]  idx_q;
	logic [3:0]  l1_cap_q;
	logic [5:0]  l2_cap_q;
	logic [2:0]  near_head_q;
	logic [3:0]  near_count_q;
	logic [4:0]  far_head_q;
	logic [5:0]  far_count_q;
	logic [31:0] cnt_q [4];
	logic [4:0]  slot_q;

	logic        n_we, f_we;
	logic [2:0]  n_addr;
	logic [4:0]  f_addr;
	logic [63:0] n_wdata, f_wdata, n_rdata, f_rdata;

	tlfc_ram #(.WIDTH(64), .DEPTH(tlfc_pkg::NEAR_DEPTH)) u_near (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata));
	tlfc_ram #(.WIDTH(64), .DEPTH(tlfc_pkg::FAR_DEPTH)) u_far (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));

	logic [5:0] cur_count, cur_cap;
	logic [4:0] cur_head, cur_mask;
	logic [4:0] probe;
	logic       key_eq;
	logic [63:0] rd_word;
	logic [5:0] eff_cap;
	logic       at_cap;
	logic [4:0] app_slot;

	always_comb begin
		cur_count = level_q ? far_count_q : {2'b0, near_count_q};
		cur_head  = level_q ? far_head_q : {2'b0, near_head_q};
		cur_mask  = level_q ? 5'd31 : 5'd7;
		cur_cap   = level_q ? l2_cap_q : {2'b0, l1_cap_q};
		eff_cap   = (cur_cap == 6'd0) ? 6'd1 :
			(!level_q && cur_cap > 6'd8) ? 6'd8 :
			(level_q && cur_cap > 6'd32) ? 6'd32 : cur_cap;
		probe     = (cur_head + idx_q[4:0]) & cur_mask;
		rd_word   = level_q ? f_rdata : n_rdata;
		key_eq    = rd_word[63:32] == key_q;
		at_cap    = (cur_count >= eff_cap) && (cur_count != 6'd0);
		app_slot  = (cur_head + (at_cap ? 5'd1 : 5'd0) +
			cur_count[4:0] - (at_cap ? 5'd1 : 5'd0)) & cur_mask;
	end

	always_comb begin
		n_we    = 1'b0;
		f_we    = 1'b0;
		n_wdata = {key_q, val_q};
		f_wdata = {key_q, val_q};
		n_addr  = probe[2:0];
		f_addr  = probe;
		if (state_q == S_PUT_WR) begin
			n_we   = !level_q;
			f_we   = level_q;
			n_addr = slot_q[2:0];
			f_addr = slot_q;
		end
	end

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			busy         <= 1'b0;
			done         <= 1'b0;
			l1_cap_q     <= 4'd8;
			l2_cap_q     <= 6'd32;
			near_head_q  <= '0;
			near_count_q <= '0;
			far_head_q   <= '0;
			far_count_q  <= '0;
			for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
			level_q      <= 1'b0;
			phase_q      <= 1'b0;
			wr_both_q    <= 1'b0;
			idx_q        <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == tlfc_pkg::REG_L1_CAP) l1_cap_q <= cfg_data[3:0];
				else l2_cap_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy      <= 1'b1;
						op_q      <= in_item.op;
						key_q     <= in_item.key;
						val_q     <= in_item.value;
						rv_q      <= 32'hFFFF_FFFF;
						level_q   <= 1'b0;
						idx_q     <= '0;
						phase_q   <= in_item.op == tlfc_pkg::OP_WRITE;
						wr_both_q <= in_item.op == tlfc_pkg::OP_WRITE;
						state_q   <= S_RD;
					end
				end
				S_RD: begin
					if (idx_q < cur_count) begin
						state_q <= S_CMP;
					end else if (phase_q) begin
						// key absent: append, evicting oldest when full
						slot_q <= app_slot;
						if (level_q) begin
							if (at_cap) far_head_q <= (far_head_q + 5'd1);
							else far_count_q <= far_count_q + 6'd1;
						end else begin
							if (at_cap) near_head_q <= near_head_q + 3'd1;
							else near_count_q <= near_count_q + 4'd1;
						end
						state_q <= S_PUT_WR;
					end else if (!level_q) begin
						cnt_q[1] <= sat_inc(cnt_q[1]);
						level_q  <= 1'b1;
						idx_q    <= '0;
					end else begin
						cnt_q[3] <= sat_inc(cnt_q[3]);
						status_q <= tlfc_pkg::ST_MISS;
						state_q  <= S_EMIT;
					end
				end
				S_CMP: begin
					if (key_eq) begin
						if (phase_q) begin
							slot_q  <= probe;
							state_q <= S_PUT_WR;
						end else if (!level_q) begin
							cnt_q[0] <= sat_inc(cnt_q[0]);
							rv_q     <= rd_word[31:0];
							status_q <= tlfc_pkg::ST_L1_HIT;
							state_q  <= S_EMIT;
						end else begin
							cnt_q[2] <= sat_inc(cnt_q[2]);
							rv_q     <= rd_word[31:0];
							val_q    <= rd_word[31:0];
							status_q <= tlfc_pkg::ST_L2_HIT;
							level_q  <= 1'b0;
							phase_q  <= 1'b1;
							idx_q    <= '0;
							state_q  <= S_RD;
						end
					end else begin
						idx_q   <= idx_q + 6'd1;
						state_q <= S_RD;
					end
				end
				S_PUT_WR: begin
					if (wr_both_q && !level_q) begin
						level_q <= 1'b1;
						idx_q   <= '0;
						state_q <= S_RD;
					end else begin
						if (wr_both_q) status_q <= tlfc_pkg::ST_WRITE;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					done    <= 1'b1;
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			out_item.status        <= (op_q == tlfc_pkg::OP_WRITE) ? tlfc_pkg::ST_WRITE
				: status_q;
			out_item.read_value    <= (op_q == tlfc_pkg::OP_WRITE) ? 32'hFFFF_FFFF : rv_q;
			out_item.first_hits    <= cnt_q[0];
			out_item.first_misses  <= cnt_q[1];
			out_item.second_hits   <= cnt_q[2];
			out_item.second_misses <= cnt_q[3];
		end
	end

endmodule

[tb/tb.sv]
// testbench for two_level_fifo_cache: random and directed reads and writes
// checked against an in-bench model of both fifo levels; depends on tlfc_pkg
`timescale 1ns / 100ps

module tb;
	import tlfc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	logic done;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_L1_CAP;
	logic [5:0] cfg_data = '0;

	two_level_fifo_cache DUT (.*);

	always #4 clk = ~clk;

	// model state
	logic [31:0] near_k [NEAR_DEPTH];
	logic [31:0] near_v [NEAR_DEPTH];
	int near_hd, near_cnt;
	logic [31:0] far_k [FAR_DEPTH];
	logic [31:0] far_v [FAR_DEPTH];
	int far_hd, far_cnt;
	logic [31:0] tally [4];
	int l1_cap, l2_cap;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int idle_pct = 0;
	int mismatches = 0;
	int accepted = 0, results_seen = 0, l2_hits_seen = 0, misses_seen = 0;
	int quiet_cycles = 0;
	logic sending = 1'b0;

	function automatic int clamp_cap(int cap, int depth);
		if (cap == 0) return 1;
		return cap > depth ? depth : cap;
	endfunction

	task automatic put_near(logic [31:0] key, logic [31:0] val);
		int s;
		s = -1;
		for (int i = 0; i < near_cnt && i < NEAR_DEPTH; i++)
			if (near_k[(near_hd + i) % NEAR_DEPTH] == key && s < 0) s = (near_hd + i) % NEAR_DEPTH;
		if (s >= 0) begin
			near_v[s] = val;
			return;
		end
		if (near_cnt >= clamp_cap(l1_cap, NEAR_DEPTH) && near_cnt > 0) begin
			near_hd = (near_hd + 1) % NEAR_DEPTH;
			near_cnt--;
		end
		if (near_cnt >= NEAR_DEPTH) return;
		s = (near_hd + near_cnt) % NEAR_DEPTH;
		near_k[s] = key;
		near_v[s] = val;
		near_cnt++;
	endtask

	task automatic put_far(logic [31:0] key, logic [31:0] val);
		int s;
		s = -1;
		for (int i = 0; i < far_cnt && i < FAR_DEPTH; i++)
			if (far_k[(far_hd + i) % FAR_DEPTH] == key && s < 0) s = (far_hd + i) % FAR_DEPTH;
		if (s >= 0) begin
			far_v[s] = val;
			return;
		end
		if (far_cnt >= clamp_cap(l2_cap, FAR_DEPTH) && far_cnt > 0) begin
			far_hd = (far_hd + 1) % FAR_DEPTH;
			far_cnt--;
		end
		if (far_cnt >= FAR_DEPTH) return;
		s = (far_hd + far_cnt) % FAR_DEPTH;
		far_k[s] = key;
		far_v[s] = val;
		far_cnt++;
	endtask

	task automatic bump(int which);
		if (tally[which] != 32'hFFFF_FFFF) tally[which]++;
	endtask

	task automatic predict_access(in_item_t it);
		out_item_t r;
		int s;
		r.status = ST_WRITE;
		r.read_value = -1;
		if (it.op == OP_WRITE) begin
			put_near(it.key, it.value);
			put_far(it.key, it.value);
		end else begin
			s = -1;
			for (int i = 0; i < near_cnt && i < NEAR_DEPTH; i++)
				if (near_k[(near_hd + i) % NEAR_DEPTH] == it.key && s < 0)
					s = (near_hd + i) % NEAR_DEPTH;
			if (s >= 0) begin
				bump(0);
				r.read_value = near_v[s];
				r.status = ST_L1_HIT;
			end else begin
				bump(1);
				for (int i = 0; i < far_cnt && i < FAR_DEPTH; i++)
					if (far_k[(far_hd + i) % FAR_DEPTH] == it.key && s < 0)
						s = (far_hd + i) % FAR_DEPTH;
				if (s >= 0) begin
					bump(2);
					r.read_value = far_v[s];
					put_near(it.key, far_v[s]);
					r.status = ST_L2_HIT;
				end else begin
					bump(3);
					r.status = ST_MISS;
				end
			end
		end
		r.first_hits = tally[0];
		r.first_misses = tally[1];
		r.second_hits = tally[2];
		r.second_misses = tally[3];
		expected_results.push_back(r);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				// item on in_item is still waiting to be taken at a rising edge
			end
			if (!sending || !busy) begin
				if (!sending && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_item <= pending_items.pop_front();
					start <= 1'b1;
					sending <= 1'b1;
				end else if (sending && !start) begin
					sending <= 1'b0;
				end
			end
		end
	end

	// acceptance and checking at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (start && !busy) begin
				predict_access(in_item);
				accepted <= accepted + 1;
				start <= 1'b0;
				sending <= 1'b0;
			end
			if (done) begin
				results_seen <= results_seen + 1;
				if (out_item.status == ST_L2_HIT) l2_hits_seen <= l2_hits_seen + 1;
				if (out_item.status == ST_MISS) misses_seen <= misses_seen + 1;
				if (expected_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected result %p", out_item);
				end else if (out_item !== expected_results[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %p got %p", expected_results[0], out_item);
					void'(expected_results.pop_front());
				end else begin
					void'(expected_results.pop_front());
				end
			end
			if (quiet_cycles > 5000) begin
				$display("watchdog: no progress");
				$display("two_level_fifo_cache verification failed");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_capacity(logic idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[5:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_L1_CAP) l1_cap = val;
		else l2_cap = val;
	endtask

	function automatic in_item_t mk(logic op, logic [31:0] key, logic [31:0] val);
		in_item_t it;
		it.op = op;
		it.key = key;
		it.value = val;
		return it;
	endfunction

	function automatic logic [31:0] pick_key(int pool);
		if ($urandom_range(15) == 0) return $urandom();
		return 32'h8000_0000 ^ ($urandom_range(pool - 1) * 32'h0101_0101);
	endfunction

	task automatic random_phase(int n, int pool, int idle);
		idle_pct = idle;
		repeat (n)
			pending_items.push_back(mk($urandom_range(2) == 0, pick_key(pool), $urandom()));
		drain();
	endtask

	initial begin
		near_hd = 0; near_cnt = 0; far_hd = 0; far_cnt = 0;
		foreach (tally[i]) tally[i] = '0;
		l1_cap = 8; l2_cap = 32;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: miss on empty, extremes, update in place, l2 refill
		pending_items.push_back(mk(OP_READ, 32'h0, 32'hFFFF_FFFF));
		pending_items.push_back(mk(OP_WRITE, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_items.push_back(mk(OP_WRITE, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_items.push_back(mk(OP_WRITE, 32'hFFFF_FFFF, 32'h0));
		pending_items.push_back(mk(OP_WRITE, 32'h0, 32'hFFFF_FFFF));
		pending_items.push_back(mk(OP_READ, 32'h8000_0000, 32'h0));
		pending_items.push_back(mk(OP_READ, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(mk(OP_WRITE, 32'h8000_0000, 32'h1234_5678));
		pending_items.push_back(mk(OP_READ, 32'h8000_0000, 32'h0));
		for (int i = 1; i <= 10; i++)
			pending_items.push_back(mk(OP_WRITE, i, i * 3));
		pending_items.push_back(mk(OP_READ, 1, 0));
		pending_items.push_back(mk(OP_READ, 10, 0));
		pending_items.push_back(mk(OP_READ, 32'h1, 0));
		pending_items.push_back(mk(OP_READ, 32'h5555_5555, 0));
		drain();

		random_phase(250, 24, 0);
		set_capacity(REG_L1_CAP, 1);
		set_capacity(REG_L2_CAP, 1);
		random_phase(150, 4, 61);
		set_capacity(REG_L1_CAP, 0);
		set_capacity(REG_L2_CAP, 0);
		random_phase(100, 4, 0);
		set_capacity(REG_L1_CAP, 15);
		set_capacity(REG_L2_CAP, 63);
		random_phase(250, 48, 16);
		set_capacity(REG_L1_CAP, 3);
		set_capacity(REG_L2_CAP, 12);
		random_phase(250, 20, 61);
		set_capacity(REG_L1_CAP, 8);
		set_capacity(REG_L2_CAP, 32);
		random_phase(200, 40, 0);

		$display("ran %0d items (%0d results, %0d l2 hits, %0d misses)",
			accepted, results_seen, l2_hits_seen, misses_seen);
		$display("capacities swept 0..15 and 0..63 under several idle rates");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("two_level_fifo_cache verification clean");
		else
			$display("two_level_fifo_cache verification failed");
		$finish;
	end
endmodule

[sim.f]
sv/tlfc_pkg.sv
sv/tlfc_ram.sv
sv/two_level_fifo_cache.sv
tb/tb.sv
